/* hdl/sida_pkg.sv */
package sida_pkg;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_NINE = 8'd57;
  localparam logic [7:0] CHAR_PLUS  = 8'd43;
  localparam logic [7:0] CHAR_MINUS = 8'd45;

  typedef logic [3:0] bcd_digit_t;

  localparam bcd_digit_t DIGIT_ADJ_MIN = 4'd5;
  localparam bcd_digit_t DIGIT_ADJ     = 4'd3;

  typedef struct packed {
    logic load;
    logic shift;
    logic emit;
  } dab_ctrl_t;

endpackage

/* hdl/sida_dabble.sv */
module sida_dabble
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = 32,
  parameter int NUM_DIGITS = 10
) (
  input  logic                  clk,
  input  dab_ctrl_t             ctrl,
  input  logic [VALUE_BITS-1:0] load_mag,
  output bcd_digit_t            top_digit
);

  localparam int BCD_BITS = NUM_DIGITS * 4;

  logic [VALUE_BITS-1:0] mag_r;
  logic [BCD_BITS-1:0]   bcd_r;
  logic [BCD_BITS-1:0]   bcd_adj;

  // add three to every digit of five or more before the shift
  always_comb begin
    bcd_digit_t dig;
    bcd_adj = '0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      dig = bcd_r[i*4 +: 4];
      if (dig >= DIGIT_ADJ_MIN) begin
        bcd_adj[i*4 +: 4] = dig + DIGIT_ADJ;
      end else begin
        bcd_adj[i*4 +: 4] = dig;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mag_r <= load_mag;
      bcd_r <= '0;
    end else if (ctrl.shift) begin
      mag_r <= {mag_r[VALUE_BITS-2:0], 1'b0};
      bcd_r <= {bcd_adj[BCD_BITS-2:0], mag_r[VALUE_BITS-1]};
    end else if (ctrl.emit) begin
      bcd_r <= {bcd_r[BCD_BITS-5:0], 4'b0000};
    end
  end

  assign top_digit = bcd_r[BCD_BITS-1 -: 4];

endmodule

/* hdl/signed_int_to_decimal_ascii_core.sv */
// Signed integer to decimal ASCII. Each input transfer carries one
// VALUE_BITS-bit two's complement value; the block returns its text one
// character per output transfer: a sign ('+' for zero and positive, '-'
// for negative), then the decimal digits most significant first with no
// leading zeros, the final character flagged by out_last. The most negative
// value is converted exactly. The magnitude goes through a shift-and-add-3
// binary to BCD unit one input bit per cycle, and in_ready is high only
// while no value is being converted.
module signed_int_to_decimal_ascii_core
  import sida_pkg::*;
#(
  parameter int VALUE_BITS = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [VALUE_BITS-1:0] in_value,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [7:0]                   out_char_code,
  output logic                         out_last
);

  localparam int NUM_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
  localparam int CNT_W      = $clog2(VALUE_BITS);
  localparam int LEFT_W     = $clog2(NUM_DIGITS + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CONV,
    S_SKIP,
    S_SIGN,
    S_DIGIT
  } state_t;

  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LEFT_W-1:0]   left_r, left_nxt;
  logic                neg_r, neg_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_char_r, out_char_nxt;
  logic                out_last_r, out_last_nxt;

  logic [VALUE_BITS-1:0] raw;
  logic [VALUE_BITS-1:0] mag;
  logic                  in_xfer;
  logic                  out_free;
  dab_ctrl_t             ctrl;
  bcd_digit_t            top_digit;

  assign raw      = $unsigned(in_value);
  assign mag      = raw[VALUE_BITS-1] ? (~raw + 1'b1) : raw;
  assign in_ready = (state_r == S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  sida_dabble #(
    .VALUE_BITS (VALUE_BITS),
    .NUM_DIGITS (NUM_DIGITS)
  ) u_dabble (
    .clk       (clk),
    .ctrl      (ctrl),
    .load_mag  (mag),
    .top_digit (top_digit)
  );

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    left_nxt      = left_r;
    neg_nxt       = neg_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    ctrl          = '0;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          ctrl.load = 1'b1;
          neg_nxt   = raw[VALUE_BITS-1];
          cnt_nxt   = CNT_W'(VALUE_BITS - 1);
          state_nxt = S_CONV;
        end
      end
      S_CONV: begin
        ctrl.shift = 1'b1;
        cnt_nxt    = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          left_nxt  = LEFT_W'(NUM_DIGITS);
          state_nxt = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zeros, always keep one digit
        if (top_digit == '0 && left_r > LEFT_W'(1)) begin
          ctrl.emit = 1'b1;
          left_nxt  = left_r - 1'b1;
        end else begin
          state_nxt = S_SIGN;
        end
      end
      S_SIGN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = neg_r ? CHAR_MINUS : CHAR_PLUS;
          out_last_nxt  = 1'b0;
          state_nxt     = S_DIGIT;
        end
      end
      S_DIGIT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = ASCII_ZERO + {4'b0000, top_digit};
          out_last_nxt  = (left_r == LEFT_W'(1));
          ctrl.emit     = 1'b1;
          left_nxt      = left_r - 1'b1;
          if (left_r == LEFT_W'(1)) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      left_r      <= '0;
      neg_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      left_r      <= left_nxt;
      neg_r       <= neg_nxt;
    end
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;

  a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> !in_ready)
    else $error("input taken while a conversion is running");

  a_digits_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIGIT || state_r == S_SIGN) |-> (left_r != '0))
    else $error("no digit left to emit");

  a_legal_char: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_char_r == CHAR_PLUS || out_char_r == CHAR_MINUS ||
                     (out_char_r >= ASCII_ZERO && out_char_r <= ASCII_NINE)))
    else $error("character outside sign and digit set");

  a_last_is_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> (out_char_r >= ASCII_ZERO &&
                                     out_char_r <= ASCII_NINE))
    else $error("final character is not a digit");

endmodule

/* dv/signed_int_to_decimal_ascii_core_tb.sv */
module signed_int_to_decimal_ascii_core_tb;
  import sida_pkg::*;

  localparam int VB = 32;
  localparam int N_RANDOM = 207;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 60;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct packed {
    logic [7:0] code;
    logic       last;
  } ascii_char_t;

  class decimal_text_board;
    ascii_char_t expected_chars[$];
    int mismatches = 0;

    function void note_value(logic [VB-1:0] raw);
      logic [VB-1:0] mag;
      logic          neg;
      logic [7:0]    digs[$];
      ascii_char_t   c;
      neg = raw[VB-1];
      mag = neg ? (~raw + 1'b1) : raw;
      do begin
        digs.push_front(8'(mag % 10));
        mag = mag / 10;
      end while (mag != 0);
      c.code = neg ? CHAR_MINUS : CHAR_PLUS;
      c.last = 1'b0;
      expected_chars.push_back(c);
      foreach (digs[i]) begin
        c.code = ASCII_ZERO + digs[i];
        c.last = (i == digs.size() - 1);
        expected_chars.push_back(c);
      end
    endfunction

    function void check_char(logic [7:0] code, logic last);
      ascii_char_t want;
      if (expected_chars.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected character %0d last %0b", code, last);
        return;
      end
      want = expected_chars.pop_front();
      if (code !== want.code || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("character mismatch: expected %0d last %0b, got %0d last %0b",
                   want.code, want.last, code, last);
      end
    endfunction

    function int pending();
      return expected_chars.size();
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic signed [VB-1:0] in_value = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_char_code;
  logic                 out_last;

  decimal_text_board board = new();
  int  send_idle_pct = 28;
  int  recv_idle_pct = 84;
  int  n_accepted = 0;
  int  cycle_count = 0;
  logic hold_rx = 1'b0;

  signed_int_to_decimal_ascii_core #(.VALUE_BITS(VB)) dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_char(out_char_code, out_last);
    out_ready <= !hold_rx && ($urandom_range(99) >= recv_idle_pct);
  end

  // long output stall so the block backs up onto its input
  initial begin
    wait (n_accepted >= 170);
    @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  task automatic offer_value(input logic [VB-1:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_value <= v;
    do @(posedge clk); while (!in_ready);
    board.note_value(v);
    n_accepted++;
  endtask

  function automatic logic [VB-1:0] random_value();
    int unsigned  d;
    longint       lo;
    longint       hi;
    logic [VB-1:0] mag;
    logic          neg;
    case ($urandom_range(9))
      0, 1, 2, 3: return VB'($urandom());
      4: begin
        lo = 1;
        for (int k = 0; k < $urandom_range(9); k++) lo = lo * 10;
        return VB'($urandom_range(1) ? -(lo + $urandom_range(2) - 1) :
                                        (lo + $urandom_range(2) - 1));
      end
      default: begin
        d = $urandom_range(10, 1);
        lo = 1;
        for (int k = 1; k < d; k++) lo = lo * 10;
        hi = lo * 10 - 1;
        if (d == 1) lo = 0;
        neg = 1'($urandom_range(1));
        if (hi > 64'd2147483647) hi = neg ? 64'd2147483648 : 64'd2147483647;
        mag = VB'($urandom_range(int'(hi), int'(lo)));
        return neg ? (~mag + 1'b1) : mag;
      end
    endcase
  endfunction

  initial begin
    logic [VB-1:0] directed[$];
    directed = '{0, 1, -1, 5, -5, 9, -9, 10, -10, 99, 100, -100, 12345,
                 999999999, 1000000000, -1000000000, 1234567890, -987654321,
                 32'h7fff0000, 32'h0000ffff, 2147483647, -2147483647,
                 32'h80000000};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) offer_value(directed[i]);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM / 3) begin
        send_idle_pct = 84;
        recv_idle_pct = 28;
      end else if (i == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      offer_value(random_value());
    end
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.pending() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
